>>> hdl/kdc_pkg.sv
// ----------------------------------------------------------------------------
// kdc_pkg
// Shared types and constants for the key debounce / double-click block.
// ----------------------------------------------------------------------------
package kdc_pkg;

    // counter widths and limits
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned CLICK_W   = 2;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CNT_W-1:0]   HOLD_MAX          = 8'd255;
    localparam logic [CLICK_W-1:0] CLICKS_FOR_TOGGLE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE_TICKS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLICK_GAP_TICKS = 8'd1;

    // configuration reset values
    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST  = 8'd3;
    localparam logic [CNT_W-1:0] CLICK_GAP_TICKS_RST = 8'd30;

    // one tick as it enters the block
    typedef struct packed {
        logic key_level;
        logic charging;
        logic device_on;
    } kdc_item_t;

    // one result per tick
    typedef struct packed {
        logic             power_toggle;
        logic             device_on_next;
        logic             key_activity;
        logic             debounced_down;
        logic [CNT_W-1:0] held_ticks;
    } kdc_result_t;

    // configuration seen by the tick logic
    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] click_gap_ticks;
    } kdc_cfg_t;

endpackage

>>> hdl/kdc_if.sv
// ----------------------------------------------------------------------------
// kdc channel interfaces
// Valid/ready channels for ticks, results and configuration writes.
// ----------------------------------------------------------------------------

// tick input channel
interface kdc_in_if;
    logic valid;
    logic ready;
    logic key_level;
    logic charging;
    logic device_on;

    modport source (output valid, output key_level, output charging, output device_on,
                    input ready);
    modport sink   (input valid, input key_level, input charging, input device_on,
                    output ready);
endinterface

// result output channel
interface kdc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      power_toggle;
    logic                      device_on_next;
    logic                      key_activity;
    logic                      debounced_down;
    logic [kdc_pkg::CNT_W-1:0] held_ticks;

    modport source (output valid, output power_toggle, output device_on_next,
                    output key_activity, output debounced_down, output held_ticks,
                    input ready);
    modport sink   (input valid, input power_toggle, input device_on_next,
                    input key_activity, input debounced_down, input held_ticks,
                    output ready);
endinterface

// configuration write channel
interface kdc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kdc_pkg::CFG_IDX_W-1:0] index;
    logic [kdc_pkg::CNT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/kdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdc_cfg_regs
// Configuration register file: debounce length and click-gap window.
// ----------------------------------------------------------------------------
module kdc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    kdc_cfg_if.sink           cfg,
    output kdc_pkg::kdc_cfg_t cfg_vals
);

    logic [kdc_pkg::CNT_W-1:0] debounce_ticks_reg;
    logic [kdc_pkg::CNT_W-1:0] click_gap_ticks_reg;
    logic                      wr_beat;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_beat   = cfg.valid & cfg.ready;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg  <= kdc_pkg::DEBOUNCE_TICKS_RST;
            click_gap_ticks_reg <= kdc_pkg::CLICK_GAP_TICKS_RST;
        end
        else if (wr_beat)
        begin
            unique case (cfg.index)
                kdc_pkg::CFG_IDX_DEBOUNCE_TICKS:  debounce_ticks_reg  <= cfg.data;
                kdc_pkg::CFG_IDX_CLICK_GAP_TICKS: click_gap_ticks_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg_vals.debounce_ticks  = debounce_ticks_reg;
    assign cfg_vals.click_gap_ticks = click_gap_ticks_reg;

endmodule

>>> hdl/kdc_tick_core.sv
// ----------------------------------------------------------------------------
// kdc_tick_core
// Key state registers and the per-tick debounce / click update.
// ----------------------------------------------------------------------------
module kdc_tick_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  kdc_pkg::kdc_item_t   item,
    input  kdc_pkg::kdc_cfg_t    cfg_vals,
    output kdc_pkg::kdc_result_t result
);

    logic                        accepted_key_reg,  accepted_key_next;
    logic                        candidate_key_reg, candidate_key_next;
    logic [kdc_pkg::CNT_W-1:0]   stable_count_reg,  stable_count_next;
    logic [kdc_pkg::CNT_W-1:0]   hold_count_reg,    hold_count_next;
    logic [kdc_pkg::CNT_W-1:0]   gap_count_reg,     gap_count_next;
    logic [kdc_pkg::CLICK_W-1:0] click_count_reg,   click_count_next;
    logic [kdc_pkg::CLICK_W-1:0] click_bumped;
    logic                        pressed;
    logic                        toggle;

    // next key state for the tick in the input stage
    always_comb
    begin
        accepted_key_next  = accepted_key_reg;
        candidate_key_next = candidate_key_reg;
        stable_count_next  = stable_count_reg;
        hold_count_next    = hold_count_reg;
        gap_count_next     = gap_count_reg;
        click_count_next   = click_count_reg;
        click_bumped       = click_count_reg + 2'd1;
        pressed            = 1'b0;
        toggle             = 1'b0;

        if (item.charging)
        begin
            accepted_key_next  = 1'b0;
            candidate_key_next = 1'b0;
            stable_count_next  = '0;
            hold_count_next    = '0;
            gap_count_next     = '0;
            click_count_next   = '0;
        end
        else
        begin
            pressed = ~item.key_level;
            if (pressed != candidate_key_reg)
            begin
                // level moved: restart the stability filter
                stable_count_next  = '0;
                candidate_key_next = pressed;
            end
            else if (stable_count_reg < cfg_vals.debounce_ticks)
            begin
                stable_count_next = stable_count_reg + 8'd1;
            end
            else
            begin
                if (accepted_key_reg != pressed)
                begin
                    // stable edge: press counts a click, release restarts gap timer
                    if (pressed)
                    begin
                        hold_count_next  = '0;
                        click_count_next = click_bumped;
                    end
                    else
                    begin
                        gap_count_next = '0;
                    end
                    if (click_count_next == kdc_pkg::CLICKS_FOR_TOGGLE)
                    begin
                        toggle           = 1'b1;
                        click_count_next = '0;
                    end
                end
                else if (!pressed)
                begin
                    // released and idle: age out a pending click
                    if (click_count_reg != '0)
                    begin
                        if (gap_count_reg >= cfg_vals.click_gap_ticks)
                            click_count_next = '0;
                        else if (gap_count_reg < kdc_pkg::HOLD_MAX)
                            gap_count_next = gap_count_reg + 8'd1;
                    end
                end
                else if (hold_count_reg < kdc_pkg::HOLD_MAX)
                begin
                    hold_count_next = hold_count_reg + 8'd1;
                end
                accepted_key_next = pressed;
            end
        end
    end

    // state registers advance once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_key_reg  <= 1'b0;
            candidate_key_reg <= 1'b0;
            stable_count_reg  <= '0;
            hold_count_reg    <= '0;
            gap_count_reg     <= '0;
            click_count_reg   <= '0;
        end
        else if (step)
        begin
            accepted_key_reg  <= accepted_key_next;
            candidate_key_reg <= candidate_key_next;
            stable_count_reg  <= stable_count_next;
            hold_count_reg    <= hold_count_next;
            gap_count_reg     <= gap_count_next;
            click_count_reg   <= click_count_next;
        end
    end

    // result fields
    assign result.power_toggle   = toggle;
    assign result.device_on_next = item.device_on ^ toggle;
    assign result.key_activity   = pressed;
    assign result.debounced_down = accepted_key_next;
    assign result.held_ticks     = hold_count_next;

    // click count never passes the toggle threshold
    a_click_bound: assert property (@(posedge clk) disable iff (!rst_n)
        click_count_reg != 2'd3)
        else $error("click count out of range");

    // a toggle always leaves no pending click
    a_toggle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && toggle |=> click_count_reg == '0)
        else $error("click count not cleared after toggle");

    // a charging tick clears the key, stable, hold and gap registers
    a_charge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.charging |=> !accepted_key_reg && !candidate_key_reg &&
            stable_count_reg == '0 && hold_count_reg == '0 && gap_count_reg == '0)
        else $error("key state not cleared while charging");

    // toggle only on a stable press edge
    a_toggle_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        toggle |-> pressed && !accepted_key_reg && !item.charging)
        else $error("toggle without stable press");

endmodule

>>> hdl/key_debounce_double_click_core.sv
// ----------------------------------------------------------------------------
// key_debounce_double_click_core
// Debounces a raw key per tick and turns a double click into a power toggle.
// ----------------------------------------------------------------------------
// path: a tick beat is held in the input register, then its result in the result register
// throughput: one tick per clock while res.ready allows; the key state update loops through the state registers
// the input stage keeps accepting while a result waits, until both stages are full
// reset: all key state cleared, debounce_ticks = 3, click_gap_ticks = 30,
// both stages empty; no clearing pass, ticks are taken right after reset
module key_debounce_double_click_core (
    input  logic      clk,
    input  logic      rst_n,
    kdc_in_if.sink    src,
    kdc_out_if.source res,
    kdc_cfg_if.sink   cfg
);

    kdc_pkg::kdc_cfg_t    cfg_vals;
    kdc_pkg::kdc_item_t   item_reg;
    kdc_pkg::kdc_result_t result_next;
    kdc_pkg::kdc_result_t result_reg;
    logic                 item_valid_reg;
    logic                 result_valid_reg;
    logic                 in_beat;
    logic                 advance;

    // configuration registers
    kdc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    // pipeline flow control
    assign advance   = item_valid_reg & (~result_valid_reg | res.ready);
    assign src.ready = ~item_valid_reg | advance;
    assign in_beat   = src.valid & src.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (src.ready)
            item_valid_reg <= src.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_reg.key_level <= src.key_level;
            item_reg.charging  <= src.charging;
            item_reg.device_on <= src.device_on;
        end
    end

    // key state update
    kdc_tick_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item_reg),
        .cfg_vals (cfg_vals),
        .result   (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (res.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign res.valid          = result_valid_reg;
    assign res.power_toggle   = result_reg.power_toggle;
    assign res.device_on_next = result_reg.device_on_next;
    assign res.key_activity   = result_reg.key_activity;
    assign res.debounced_down = result_reg.debounced_down;
    assign res.held_ticks     = result_reg.held_ticks;

    // a stalled tick stays in the input stage
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("tick lost while stalled");

    // a finished tick always lands in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("result beat lost");

    // no new tick is taken while both stages are full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && result_valid_reg && !res.ready |-> !src.ready)
        else $error("input taken while pipeline full");

endmodule
